### hdl/mpau_pkg.sv
// ----------------------------------------------------------------------------
// mpau_pkg
// Shared types, constants and helpers for the mocap pose / angle unwrap block.
// ----------------------------------------------------------------------------
package mpau_pkg;

   // Scale register
   localparam int unsigned FPM_W = 20;
   localparam logic [FPM_W-1:0] FPM_RESET = 20'd215013;   // 3.28084 ft/m, Q4.16

   // Shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 36;
   localparam int unsigned MUL_B_W = 28;
   localparam int unsigned PROD_W  = 64;

   // Angle constants, Q32.32 radians
   localparam logic signed [63:0] TWO_PI_Q32        = 64'sd26986075409;
   localparam logic signed [63:0] PI_Q32            = 64'sd13493037705;
   localparam logic signed [63:0] HALF_PI_Q32       = 64'sd6746518852;
   localparam logic signed [63:0] THREE_HALF_PI_Q32 = 64'sd20239556557;

   // pi/180 scaled by 2^32
   localparam logic [MUL_B_W-1:0] DEG_TO_RAD_Q32 = 28'd74961321;
   // floor(2^48 / TWO_PI_Q32): reciprocal for the revolution count
   localparam logic [MUL_B_W-1:0] INV_TWO_PI     = 28'd10430;

   // Rounding half LSB and the y offset (4.0 ft), Q16.16
   localparam logic signed [63:0] HALF_LSB = 64'sd32768;
   localparam logic signed [63:0] FOUR_Q16 = 64'sd262144;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_MX,
      S_MY,
      S_MYAW,
      S_MQ,
      S_MB,
      S_DIFF,
      S_CORR,
      S_SUM,
      S_RND,
      S_DONE
   } mpau_state_type;

   // Saturate a rounded Q16.16 value to 32 bits
   function automatic logic [31:0] sat_q16(input logic signed [47:0] v);
      logic [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/mpau_intf.sv
// ----------------------------------------------------------------------------
// mpau_intf
// Valid/ready channel interfaces for capture frames and pose results.
// ----------------------------------------------------------------------------
interface mpau_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_m;
   logic signed [31:0] y_m;
   logic signed [24:0] yaw_deg;
   logic               pos_ok;
   logic [23:0]        frame_number;
   logic [15:0]        body_id;
   logic signed [31:0] robot_theta;

   modport source (
      output valid, x_m, y_m, yaw_deg, pos_ok, frame_number, body_id, robot_theta,
      input  ready
   );
   modport sink (
      input  valid, x_m, y_m, yaw_deg, pos_ok, frame_number, body_id, robot_theta,
      output ready
   );
endinterface

interface mpau_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   logic signed [31:0] x_ft;
   logic signed [31:0] y_ft;
   logic signed [31:0] theta_out;
   logic [31:0]        frame_errors;
   logic [31:0]        id_errors;

   modport source (
      output valid, valid_res, x_ft, y_ft, theta_out, frame_errors, id_errors,
      input  ready
   );
   modport sink (
      input  valid, valid_res, x_ft, y_ft, theta_out, frame_errors, id_errors,
      output ready
   );
endinterface

### hdl/mpau_mul.sv
// ----------------------------------------------------------------------------
// mpau_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mpau_mul
   import mpau_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // full-width signed product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hdl/mocap_pose_angle_unwrap.sv
// ----------------------------------------------------------------------------
// mocap_pose_angle_unwrap
// Scales a capture position to feet, unwraps the yaw onto the revolution
// nearest the robot heading, and counts repeated frames and body id changes.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------------------
//  req_ch  | in  | capture frame plus robot heading (valid/ready)
//  rsp_ch  | out | pose, valid flag and both error counts (valid/ready)
//  csr     | in  | feet_per_meter write (csr_wr_en / csr_wr_data)
//
//  After acceptance a transaction makes five passes through the one shared
//  multiplier, then DIFF, CORR, SUM and RND before rsp valid. req ready is
//  high only in idle; the next frame can be taken the cycle after the
//  result transaction completes, none before. The result holds while rsp
//  ready is low. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
module mocap_pose_angle_unwrap
   import mpau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   mpau_req_if.sink         req_ch,
   mpau_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [FPM_W-1:0] csr_wr_data
);

   localparam logic [35:0] TWO_PI_U = TWO_PI_Q32[35:0];

   mpau_state_type state_ff, state_in;

   // control state
   logic [FPM_W-1:0] fpm_ff;
   logic [24:0]      last_frame_ff, last_frame_in;
   logic [31:0]      frame_err_ff, frame_err_in;
   logic [31:0]      id_err_ff, id_err_in;
   logic             first_seen_ff, first_seen_in;
   logic [15:0]      latched_id_ff, latched_id_in;

   // captured frame
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [24:0] yaw_ff, yaw_in;
   logic signed [31:0] theta_ff, theta_in;
   logic               pose_ff, pose_in;

   // working registers
   logic [31:0]        x_res_ff, x_res_in;
   logic [31:0]        y_res_ff, y_res_in;
   logic [31:0]        th_res_ff, th_res_in;
   logic signed [37:0] o_ff, o_in;
   logic [35:0]        t_raw_ff, t_raw_in;
   logic [47:0]        babs_ff, babs_in;
   logic signed [36:0] t_ff, t_in;
   logic signed [48:0] b_ff, b_in;
   logic signed [51:0] sum_ff, sum_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;

   logic accept;
   logic [31:0] theta_abs;
   logic [47:0] h_abs;
   logic signed [63:0] x_round, y_round, o_round, th_round;
   logic [35:0] t_fix;
   logic [47:0] babs_fix;
   logic signed [63:0] t64, adj;

   mpau_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign theta_abs = theta_ff[31] ? 32'(-theta_ff) : 32'(theta_ff);
   assign h_abs     = {theta_abs, 16'd0};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_ch.valid) state_in = S_MX;
         S_MX:    state_in = S_MY;
         S_MY:    state_in = S_MYAW;
         S_MYAW:  state_in = S_MQ;
         S_MQ:    state_in = S_MB;
         S_MB:    state_in = S_DIFF;
         S_DIFF:  state_in = S_CORR;
         S_CORR:  state_in = S_SUM;
         S_SUM:   state_in = S_RND;
         S_RND:   state_in = S_DONE;
         S_DONE:  if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: handshakes and multiplier operands
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         S_IDLE: req_ch.ready = 1'b1;
         S_MX: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(fpm_ff);
         end
         S_MY: begin
            mul_a = MUL_A_W'(y_ff);
            mul_b = MUL_B_W'(fpm_ff);
         end
         S_MYAW: begin
            mul_a = MUL_A_W'(yaw_ff);
            mul_b = DEG_TO_RAD_Q32;
         end
         S_MQ: begin
            mul_a = {4'd0, theta_abs};
            mul_b = INV_TWO_PI;
         end
         S_MB: begin
            // estimated revolution count times 2pi
            mul_a = TWO_PI_Q32[MUL_A_W-1:0];
            mul_b = {14'd0, prod_ff[45:32]};
         end
         S_DIFF, S_CORR, S_SUM, S_RND: ;
         S_DONE: rsp_ch.valid = 1'b1;
         default: ;
      endcase
   end

   // rounding of the registered product and of the angle sum
   assign x_round  = (-prod_ff + HALF_LSB) >>> 16;
   assign y_round  = ((prod_ff + HALF_LSB) >>> 16) + FOUR_Q16;
   assign o_round  = (prod_ff + HALF_LSB) >>> 16;
   assign th_round = (64'(sum_ff) + HALF_LSB) >>> 16;

   // remainder correction: estimate is at most one revolution low
   assign t_fix    = (t_raw_ff >= TWO_PI_U) ? t_raw_ff - TWO_PI_U : t_raw_ff;
   assign babs_fix = (t_raw_ff >= TWO_PI_U) ? babs_ff + 48'(TWO_PI_U) : babs_ff;

   // quadrant case analysis: pick -2pi, 0 or +2pi
   assign t64 = 64'(t_ff);
   always_comb begin
      adj = '0;
      if (t64 > 0) begin
         if (t64 < PI_Q32) begin
            if (o_ff < 0 && t64 > HALF_PI_Q32) adj = TWO_PI_Q32;
         end else begin
            if (o_ff <= 0 || t64 > THREE_HALF_PI_Q32) adj = TWO_PI_Q32;
         end
      end else if (t64 > -PI_Q32) begin
         if (o_ff > 0 && t64 < -HALF_PI_Q32) adj = -TWO_PI_Q32;
      end else begin
         if (o_ff >= 0 || t64 < -THREE_HALF_PI_Q32) adj = -TWO_PI_Q32;
      end
   end

   // datapath and counter next values
   always_comb begin
      last_frame_in = last_frame_ff;
      frame_err_in  = frame_err_ff;
      id_err_in     = id_err_ff;
      first_seen_in = first_seen_ff;
      latched_id_in = latched_id_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      yaw_in        = yaw_ff;
      theta_in      = theta_ff;
      pose_in       = pose_ff;
      x_res_in      = x_res_ff;
      y_res_in      = y_res_ff;
      th_res_in     = th_res_ff;
      o_in          = o_ff;
      t_raw_in      = t_raw_ff;
      babs_in       = babs_ff;
      t_in          = t_ff;
      b_in          = b_ff;
      sum_in        = sum_ff;

      // frame capture and error counting
      if (accept) begin
         x_in          = req_ch.x_m;
         y_in          = req_ch.y_m;
         yaw_in        = req_ch.yaw_deg;
         theta_in      = req_ch.robot_theta;
         pose_in       = req_ch.pos_ok && (req_ch.x_m != 0) && (req_ch.y_m != 0)
                         && (req_ch.yaw_deg != 0);
         last_frame_in = {1'b0, req_ch.frame_number};
         if ({1'b0, req_ch.frame_number} == last_frame_ff) begin
            frame_err_in = frame_err_ff + 32'd1;
         end
         if (first_seen_ff) begin
            latched_id_in = req_ch.body_id;
            first_seen_in = 1'b0;
         end else if (latched_id_ff != req_ch.body_id) begin
            id_err_in = id_err_ff + 32'd1;
         end
      end

      case (state_ff)
         S_MY:   x_res_in = sat_q16(x_round[47:0]);
         S_MYAW: y_res_in = sat_q16(y_round[47:0]);
         S_MQ:   o_in     = o_round[37:0];
         S_DIFF: begin
            t_raw_in = 36'(h_abs - prod_ff[47:0]);
            babs_in  = prod_ff[47:0];
         end
         S_CORR: begin
            // truncating division: remainder takes the heading's sign
            t_in = theta_ff[31] ? -$signed({1'b0, t_fix}) : $signed({1'b0, t_fix});
            b_in = theta_ff[31] ? -$signed({1'b0, babs_fix}) : $signed({1'b0, babs_fix});
         end
         S_SUM:  sum_in    = 52'(64'(b_ff) + 64'(o_ff) + adj);
         S_RND:  th_res_in = sat_q16(th_round[47:0]);
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fpm_ff        <= FPM_RESET;
         last_frame_ff <= '1;
         frame_err_ff  <= '0;
         id_err_ff     <= '0;
         first_seen_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) fpm_ff <= csr_wr_data;
         last_frame_ff <= last_frame_in;
         frame_err_ff  <= frame_err_in;
         id_err_ff     <= id_err_in;
         first_seen_ff <= first_seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      latched_id_ff <= latched_id_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      yaw_ff        <= yaw_in;
      theta_ff      <= theta_in;
      pose_ff       <= pose_in;
      x_res_ff      <= x_res_in;
      y_res_ff      <= y_res_in;
      th_res_ff     <= th_res_in;
      o_ff          <= o_in;
      t_raw_ff      <= t_raw_in;
      babs_ff       <= babs_in;
      t_ff          <= t_in;
      b_ff          <= b_in;
      sum_ff        <= sum_in;
   end

   // result fields; pose fields read zero when no update was made
   assign rsp_ch.valid_res    = pose_ff;
   assign rsp_ch.x_ft         = pose_ff ? x_res_ff : 32'd0;
   assign rsp_ch.y_ft         = pose_ff ? y_res_ff : 32'd0;
   assign rsp_ch.theta_out    = pose_ff ? th_res_ff : 32'd0;
   assign rsp_ch.frame_errors = frame_err_ff;
   assign rsp_ch.id_errors    = id_err_ff;

endmodule
